// ===== hdl/sqp_pkg.sv =====
`timescale 1ns / 1ps

package sqp_pkg;

  // widths fixed by the field formats
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;
  localparam int unsigned CFG_W            = 32;
  localparam int unsigned CODE_W           = 16;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned CNT_W            = 3;
  localparam int unsigned PROD_W           = 64;
  localparam int unsigned MODE_W           = 3;
  localparam int unsigned IDX_W            = 2;

  // output code formats
  typedef enum logic [MODE_W-1:0] {
    MODE_1BIT  = 3'd0,
    MODE_2BIT  = 3'd1,
    MODE_4BIT  = 3'd2,
    MODE_8BIT  = 3'd3,
    MODE_16BIT = 3'd4
  } pack_mode_e;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PACK_MODE  = 2'd0,
    REG_RANGE_LOW  = 2'd1,
    REG_RANGE_HIGH = 2'd2,
    REG_SCALE      = 2'd3
  } reg_idx_e;

  // reset values of the configuration registers
  localparam logic [MODE_W-1:0]       PACK_MODE_RST  = MODE_8BIT;
  localparam logic signed [CFG_W-1:0] RANGE_LOW_RST  = 32'sd0;
  localparam logic signed [CFG_W-1:0] RANGE_HIGH_RST = 32'sd65536;
  localparam logic [CFG_W-1:0]        SCALE_RST      = 32'd16711680;

  typedef struct packed {
    logic [MODE_W-1:0]       pack_mode;
    logic signed [CFG_W-1:0] range_low;
    logic signed [CFG_W-1:0] range_high;
    logic [CFG_W-1:0]        scale_factor;
  } sqp_cfg_t;

  // packer status seen by the top level
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             eob_flush;
  } sqp_pack_stat_t;

endpackage

// ===== hdl/sqp_if.sv =====
`timescale 1ns / 1ps

// sample channel
interface sqp_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = sqp_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_value;
  logic                           end_of_block;

  modport source (output valid, output sample_value, output end_of_block, input ready);
  modport sink   (input valid, input sample_value, input end_of_block, output ready);
endinterface

// code channel
interface sqp_code_if;
  import sqp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] packed_code;
  logic              block_done;

  modport source (output valid, output packed_code, output block_done, input ready);
  modport sink   (input valid, input packed_code, input block_done, output ready);
endinterface

// ===== hdl/sqp_front.sv =====
`timescale 1ns / 1ps

module sqp_front #(
  parameter int unsigned SAMPLE_WIDTH = sqp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sqp_pkg::sqp_cfg_t                  cfg_i,
  sqp_sample_if.sink                         sample_ch,
  output logic                               diff_valid_o,
  input  logic                               diff_ready_i,
  output logic [sqp_pkg::CFG_W-1:0]          diff_o,
  output logic                               eob_o
);
  import sqp_pkg::*;

  localparam int unsigned XW = (SAMPLE_WIDTH > CFG_W) ? SAMPLE_WIDTH : CFG_W;

  logic                           in_v_q;
  logic signed [SAMPLE_WIDTH-1:0] smp_q;
  logic                           in_eob_q;
  logic                           diff_v_q;
  logic [CFG_W-1:0]               diff_q;
  logic                           eob_q;
  logic                           stage_ready;

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] hi_ext;
  logic signed [XW-1:0] lo_ext;
  logic signed [XW-1:0] clamped;
  logic signed [XW:0]   diff_full;
  logic                 below;
  logic [CFG_W-1:0]     diff_d;

  assign stage_ready     = !diff_v_q || diff_ready_i;
  assign sample_ch.ready = !in_v_q || stage_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (sample_ch.ready) begin
      in_v_q <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_ch.valid && sample_ch.ready) begin
      smp_q    <= sample_ch.sample_value;
      in_eob_q <= sample_ch.end_of_block;
    end
  end

  // limit to the upper level, zero below the lower level, offset by it
  always_comb begin
    x_ext     = XW'(smp_q);
    hi_ext    = XW'(cfg_i.range_high);
    lo_ext    = XW'(cfg_i.range_low);
    clamped   = (x_ext > hi_ext) ? hi_ext : x_ext;
    below     = clamped < lo_ext;
    diff_full = (XW+1)'(clamped) - (XW+1)'(lo_ext);
    diff_d    = below ? '0 : diff_full[CFG_W-1:0];
  end

  // offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_v_q <= 1'b0;
    end else if (stage_ready) begin
      diff_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_v_q && stage_ready) begin
      diff_q <= diff_d;
      eob_q  <= in_eob_q;
    end
  end

  assign diff_valid_o = diff_v_q;
  assign diff_o       = diff_q;
  assign eob_o        = eob_q;

endmodule

// ===== hdl/sqp_scale.sv =====
`timescale 1ns / 1ps

module sqp_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sqp_pkg::CFG_W-1:0]   scale_i,
  input  logic                        diff_valid_i,
  output logic                        diff_ready_o,
  input  logic [sqp_pkg::CFG_W-1:0]   diff_i,
  input  logic                        eob_i,
  output logic                        prod_valid_o,
  input  logic                        prod_ready_i,
  output logic [sqp_pkg::PROD_W-1:0]  prod_o,
  output logic                        eob_o
);
  import sqp_pkg::*;

  logic              prod_v_q;
  logic [PROD_W-1:0] prod_q;
  logic              eob_q;

  assign diff_ready_o = !prod_v_q || prod_ready_i;

  // Q32.32 product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else if (diff_ready_o) begin
      prod_v_q <= diff_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (diff_valid_i && diff_ready_o) begin
      prod_q <= PROD_W'(diff_i) * PROD_W'(scale_i);
      eob_q  <= eob_i;
    end
  end

  assign prod_valid_o = prod_v_q;
  assign prod_o       = prod_q;
  assign eob_o        = eob_q;

endmodule

// ===== hdl/sqp_pack.sv =====
`timescale 1ns / 1ps

module sqp_pack (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sqp_pkg::MODE_W-1:0]   mode_i,
  input  logic                         clear_i,
  input  logic                         prod_valid_i,
  output logic                         prod_ready_o,
  input  logic [sqp_pkg::PROD_W-1:0]   prod_i,
  input  logic                         eob_i,
  sqp_code_if.source                   code_ch,
  output sqp_pkg::sqp_pack_stat_t      stat_o
);
  import sqp_pkg::*;

  localparam logic [CFG_W-1:0] RND_HALF = CFG_W'(1) << (CFG_W - 1);

  logic              out_v_q;
  logic [CODE_W-1:0] out_code_q;
  logic              out_eob_q;
  logic [BYTE_W-1:0] acc_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [CFG_W-1:0]  q_int;
  logic [CFG_W-1:0]  q_rem;
  logic              rnd_up;
  logic [CFG_W:0]    q_rnd;
  logic [CODE_W-1:0] cmax;
  logic [CODE_W-1:0] code;
  logic [BYTE_W-1:0] term;
  logic [BYTE_W-1:0] acc_new;
  logic [CNT_W:0]    group;
  logic              packing;
  logic              last;
  logic              emit;
  logic              consume;

  assign prod_ready_o = !out_v_q || code_ch.ready;
  assign consume      = prod_valid_i && prod_ready_o;

  // round half to even, saturate at the mode's largest code
  always_comb begin
    q_int  = prod_i[PROD_W-1:CFG_W];
    q_rem  = prod_i[CFG_W-1:0];
    rnd_up = (q_rem > RND_HALF) || ((q_rem == RND_HALF) && q_int[0]);
    q_rnd  = {1'b0, q_int} + (CFG_W+1)'(rnd_up);
    case (mode_i)
      MODE_1BIT, MODE_4BIT: cmax = CODE_W'(16'h000F);
      MODE_2BIT:            cmax = CODE_W'(16'h0003);
      MODE_8BIT:            cmax = CODE_W'(16'h00FF);
      default:              cmax = CODE_W'(16'hFFFF);
    endcase
    code = (q_rnd > (CFG_W+1)'(cmax)) ? cmax : q_rnd[CODE_W-1:0];
  end

  // place the code in the byte being built
  always_comb begin
    packing = 1'b1;
    term    = '0;
    group   = (CNT_W+1)'(1);
    case (mode_i)
      MODE_1BIT: begin
        term  = BYTE_W'(code != '0) << cnt_q;
        group = (CNT_W+1)'(8);
      end
      MODE_2BIT: begin
        term  = BYTE_W'(code[1:0]) << {cnt_q[1:0], 1'b0};
        group = (CNT_W+1)'(4);
      end
      MODE_4BIT: begin
        term  = BYTE_W'(code[3:0]) << {cnt_q[0], 2'b00};
        group = (CNT_W+1)'(2);
      end
      default: begin
        packing = 1'b0;
      end
    endcase
    acc_new = acc_q | term;
    last    = ({1'b0, cnt_q} + (CNT_W+1)'(1)) >= group;
    emit    = !packing || last;
  end

  // packer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (clear_i) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (consume) begin
      if (emit || eob_i) begin
        acc_q <= '0;
        cnt_q <= '0;
      end else begin
        acc_q <= acc_new;
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (consume && emit) begin
      out_v_q <= 1'b1;
    end else if (code_ch.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && emit) begin
      out_code_q <= packing ? CODE_W'(acc_new) : code;
      out_eob_q  <= eob_i;
    end
  end

  assign code_ch.valid       = out_v_q;
  assign code_ch.packed_code = out_code_q;
  assign code_ch.block_done  = out_eob_q;

  assign stat_o.count     = cnt_q;
  assign stat_o.eob_flush = consume && eob_i;

endmodule

// ===== hdl/sample_quantize_pack.sv =====
// Linear quantizer with bit packing. Signed Q16.16 samples are limited to
// range_high, give code 0 below range_low, and otherwise have range_low
// subtracted and are multiplied by the unsigned Q16.16 scale_factor; the
// product is rounded half to even and saturated at the mode's largest code.
// 8-bit and 16-bit modes give one item per sample; 2-bit and 4-bit modes pack
// four or two codes per byte, first code in the low bits; 1-bit mode packs
// eight "code above zero" flags per byte, first in bit 0. A partial byte at
// the end of a block is dropped. One sample is taken every clock while the
// code channel does not stall; a result passes through the input register,
// offset register, the 32x32 multiplier register and output register.
// Backpressure on the code channel stalls only the stages that are full.
`timescale 1ns / 1ps

module sample_quantize_pack #(
  parameter int unsigned SAMPLE_WIDTH = sqp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sqp_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [sqp_pkg::CFG_W-1:0]   cfg_data_i,
  sqp_sample_if.sink                  sample_ch,
  sqp_code_if.source                  code_ch
);
  import sqp_pkg::*;

  sqp_cfg_t         cfg_q;
  logic             pack_clear;
  logic             diff_valid;
  logic             diff_ready;
  logic [CFG_W-1:0] diff;
  logic             diff_eob;
  logic             prod_valid;
  logic             prod_ready;
  logic [PROD_W-1:0] prod;
  logic             prod_eob;
  sqp_pack_stat_t   pack_stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pack_mode    <= PACK_MODE_RST;
      cfg_q.range_low    <= RANGE_LOW_RST;
      cfg_q.range_high   <= RANGE_HIGH_RST;
      cfg_q.scale_factor <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PACK_MODE:  cfg_q.pack_mode    <= cfg_data_i[MODE_W-1:0];
        REG_RANGE_LOW:  cfg_q.range_low    <= cfg_data_i;
        REG_RANGE_HIGH: cfg_q.range_high   <= cfg_data_i;
        REG_SCALE:      cfg_q.scale_factor <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // a mode change empties the packer
  assign pack_clear = cfg_we_i && (cfg_idx_i == REG_PACK_MODE);

  sqp_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .sample_ch    (sample_ch),
    .diff_valid_o (diff_valid),
    .diff_ready_i (diff_ready),
    .diff_o       (diff),
    .eob_o        (diff_eob)
  );

  sqp_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scale_i      (cfg_q.scale_factor),
    .diff_valid_i (diff_valid),
    .diff_ready_o (diff_ready),
    .diff_i       (diff),
    .eob_i        (diff_eob),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod),
    .eob_o        (prod_eob)
  );

  sqp_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (cfg_q.pack_mode),
    .clear_i      (pack_clear),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod),
    .eob_i        (prod_eob),
    .code_ch      (code_ch),
    .stat_o       (pack_stat)
  );

  // packer only holds codes in the packed modes
  a_count_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pack_stat.count != '0) |->
      (cfg_q.pack_mode == MODE_1BIT || cfg_q.pack_mode == MODE_2BIT ||
       cfg_q.pack_mode == MODE_4BIT))
    else $error("packer holds codes outside a packed mode");

  // fill count stays below the group size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((cfg_q.pack_mode == MODE_4BIT) && (pack_stat.count > CNT_W'(1))) &&
    !((cfg_q.pack_mode == MODE_2BIT) && (pack_stat.count > CNT_W'(3))))
    else $error("packer count beyond group size");

  // end of block leaves the packer empty
  a_eob_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pack_stat.eob_flush |=> (pack_stat.count == '0))
    else $error("packer not cleared at end of block");

endmodule
